// ----- src/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the integer literal scanner
// Character codes, radix codes, scan phases and the state/result records.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    localparam int VALUE_BITS  = 64;              // accumulator width, 8..64
    localparam int OUT_VALUE_W = 64;              // width of the value field
    localparam int RADIX_W     = 5;
    localparam int PROD_W      = VALUE_BITS + 4;  // acc * 16 + 15 fits

    // scan phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ZERO    = 2'd1;
    localparam logic [1:0] PH_DIGITS  = 2'd2;
    localparam logic [1:0] PH_SWALLOW = 2'd3;

    // radix codes
    localparam logic [RADIX_W-1:0] RADIX_2  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_8  = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_10 = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_16 = 5'd16;

    // character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UB    = 8'h42;

    typedef struct packed {
        logic [1:0]            phase;
        logic [VALUE_BITS-1:0] acc;
        logic [RADIX_W-1:0]    base;
        logic                  bad;
        logic                  ovf;
    } t_scan_state;

    typedef struct packed {
        logic                   consumed;
        logic                   done_res;
        logic [OUT_VALUE_W-1:0] value;
        logic [RADIX_W-1:0]     radix;
        logic                   digit_error;
        logic                   overflow;
    } t_result;

endpackage

`default_nettype wire

// ----- src/ils_if.sv -----
// ----------------------------------------------------------------------------
// ils_in_if / ils_out_if: item channels of the integer literal scanner
// Valid/ready handshake; an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ils_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;

    modport source (output valid, ch, start_req, input ready);
    modport sink   (input valid, ch, start_req, output ready);
endinterface

interface ils_out_if;
    logic        valid;
    logic        ready;
    logic        consumed;
    logic        done_res;
    logic [63:0] value;
    logic [4:0]  radix;
    logic        digit_error;
    logic        overflow;

    modport source (output valid, consumed, done_res, value, radix, digit_error, overflow,
                    input ready);
    modport sink   (input valid, consumed, done_res, value, radix, digit_error, overflow,
                    output ready);
endinterface

`default_nettype wire

// ----- src/integer_literal_scanner.sv -----
// Pipeline: an accepted item passes from the input register to the result register.
// Throughput: one item per cycle unless the result sink stalls; the radix multiply-add
// is shifts and at most two adds.
// A full result register is taken in the same cycle as the next item advances.
// Reset (synchronous, active low): scanner idle, accumulator 0, radix 10, flags clear,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// integer_literal_scanner: character-serial integer literal parser
// Handles 0x/0b/leading-zero prefixes, underscores, digit errors and overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_scanner (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ils_in_if.sink    i_in,
    ils_out_if.source o_out
);
    import ils_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_ch;
    logic        r_in_start;
    logic        r_out_valid;
    t_result     r_out;
    t_scan_state r_st;
    t_scan_state n_st;
    t_result     n_out;
    logic        advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    ils_step u_step (
        .i_cur   (r_st),
        .i_ch    (r_in_ch),
        .i_start (r_in_start),
        .o_nxt   (n_st),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '{phase: PH_IDLE, acc: '0, base: RADIX_10, bad: 1'b0, ovf: 1'b0};
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ch    <= i_in.ch;
            r_in_start <= i_in.start_req;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.consumed    = r_out.consumed;
    assign o_out.done_res    = r_out.done_res;
    assign o_out.value       = r_out.value;
    assign o_out.radix       = r_out.radix;
    assign o_out.digit_error = r_out.digit_error;
    assign o_out.overflow    = r_out.overflow;

    // swallowing digits only happens after an overflow
    a_swallow_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_SWALLOW |-> r_st.ovf)
        else $error("swallow phase without overflow flag");

    a_base_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.base == RADIX_2 || r_st.base == RADIX_8 ||
        r_st.base == RADIX_10 || r_st.base == RADIX_16)
        else $error("illegal radix in state");

    // a finished literal is never reported on a consumed character
    a_done_unconsumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.consumed)
        else $error("done result on consumed character");

    // scan state moves only when an item passes to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_st))
        else $error("scan state changed without an item");

endmodule

`default_nettype wire

// ----- src/ils_step.sv -----
// ----------------------------------------------------------------------------
// ils_step: next-state and result logic for one character
// Prefix detection, digit decode, multiply-add by the radix with overflow check.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_step (
    input  ils_pkg::t_scan_state i_cur,
    input  logic [7:0]           i_ch,
    input  logic                 i_start,
    output ils_pkg::t_scan_state o_nxt,
    output ils_pkg::t_result     o_res
);
    import ils_pkg::*;

    logic                  is_dec;
    logic                  is_lo;
    logic                  is_up;
    logic                  is_digit;
    logic [3:0]            dval;
    logic                  run;
    logic [VALUE_BITS-1:0] e_acc;
    logic [RADIX_W-1:0]    e_base;
    logic                  e_bad;
    logic                  e_ovf;
    logic                  oor;
    logic [3:0]            dig;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     sum;
    logic                  sum_ovf;
    logic                  consumed;
    logic                  done;

    always_comb begin
        is_dec   = (i_ch >= CH_0)  && (i_ch <= CH_9);
        is_lo    = (i_ch >= CH_LA) && (i_ch <= CH_LF);
        is_up    = (i_ch >= CH_UA) && (i_ch <= CH_UF);
        is_digit = is_dec || is_lo || is_up;
        // 'a'/'A' have low nibble 1, so +9 maps them to 10
        dval     = is_dec ? i_ch[3:0] : (i_ch[3:0] + 4'd9);
    end

    // phase dispatch: selects the state fed to the digit step
    always_comb begin
        o_nxt    = i_cur;
        consumed = 1'b0;
        done     = 1'b0;
        run      = 1'b0;
        e_acc    = i_cur.acc;
        e_base   = i_cur.base;
        e_bad    = i_cur.bad;
        e_ovf    = i_cur.ovf;

        if (i_start) begin
            e_acc  = '0;
            e_base = RADIX_10;
            e_bad  = 1'b0;
            e_ovf  = 1'b0;
            o_nxt  = '{phase: PH_ZERO, acc: '0, base: RADIX_10, bad: 1'b0, ovf: 1'b0};
            if (i_ch == CH_0) begin
                consumed = 1'b1;
            end else begin
                run = 1'b1;
            end
        end else begin
            case (i_cur.phase)
                PH_ZERO: begin
                    if (i_ch == CH_LX || i_ch == CH_UX) begin
                        o_nxt.base  = RADIX_16;
                        o_nxt.phase = PH_DIGITS;
                        consumed    = 1'b1;
                    end else if (i_ch == CH_LB || i_ch == CH_UB) begin
                        o_nxt.base  = RADIX_2;
                        o_nxt.phase = PH_DIGITS;
                        consumed    = 1'b1;
                    end else begin
                        e_base = RADIX_8;
                        run    = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    run = 1'b1;
                end
                PH_SWALLOW: begin
                    if (is_dec) begin
                        consumed = 1'b1;
                    end else begin
                        o_nxt.acc   = '0;
                        o_nxt.phase = PH_IDLE;
                        done        = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        oor = ({1'b0, dval} >= e_base);
        dig = oor ? 4'd0 : dval;

        // acc * radix as shifts; radix 10 is 8x + 2x
        case (e_base)
            RADIX_2:  prod = {3'b000, e_acc, 1'b0};
            RADIX_8:  prod = {1'b0, e_acc, 3'b000};
            RADIX_16: prod = {e_acc, 4'b0000};
            default:  prod = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0};
        endcase
        sum     = prod + PROD_W'(dig);
        sum_ovf = |sum[PROD_W-1:VALUE_BITS];

        if (run) begin
            o_nxt.phase = PH_DIGITS;
            o_nxt.acc   = e_acc;
            o_nxt.base  = e_base;
            o_nxt.bad   = e_bad;
            o_nxt.ovf   = e_ovf;
            if (i_ch == CH_UNDER) begin
                consumed = 1'b1;
            end else if (!is_digit) begin
                o_nxt.phase = PH_IDLE;
                done        = 1'b1;
            end else begin
                o_nxt.bad = e_bad | oor;
                if (sum_ovf) begin
                    o_nxt.ovf = 1'b1;
                    o_nxt.acc = '0;
                    if (is_dec) begin
                        o_nxt.phase = PH_SWALLOW;
                        consumed    = 1'b1;
                    end else begin
                        o_nxt.phase = PH_IDLE;
                        done        = 1'b1;
                    end
                end else begin
                    o_nxt.acc = sum[VALUE_BITS-1:0];
                    consumed  = 1'b1;
                end
            end
        end

        o_res.consumed = consumed;
        o_res.done_res = done;
        if (done) begin
            o_res.value       = OUT_VALUE_W'(o_nxt.acc);
            o_res.radix       = o_nxt.base;
            o_res.digit_error = o_nxt.bad;
            o_res.overflow    = o_nxt.ovf;
        end else begin
            o_res.value       = '0;
            o_res.radix       = RADIX_10;
            o_res.digit_error = 1'b0;
            o_res.overflow    = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for integer_literal_scanner
// Drives character streams (hex/binary/octal/decimal literals, underscores,
// bad digits, overflow runs, restarts and noise) with random idle on both
// channels, predicts every result in step with the scanner and checks them.
// ----------------------------------------------------------------------------

module tb;

    import ils_pkg::*;

    localparam int SIDE_IN      = 0;
    localparam int SIDE_OUT     = 1;
    localparam int RANDOM_ITEMS = 1200;
    localparam int MAX_REPORTS  = 10;

    // Tracks the scanner's state and holds the results it owes, oldest first.
    class literal_tracker;
        logic [1:0]            phase;
        logic [VALUE_BITS-1:0] acc;
        logic [RADIX_W-1:0]    base;
        logic                  bad;
        logic                  ovf;
        t_result               scan_results_due[$];
        int unsigned           mismatches;

        function new();
            phase      = PH_IDLE;
            acc        = '0;
            base       = RADIX_10;
            bad        = 1'b0;
            ovf        = 1'b0;
            mismatches = 0;
        endfunction

        // One character inside a literal body.
        function void add_digit(input logic [7:0] c, output logic cons, output logic done);
            int                    dv;
            logic [RADIX_W-1:0]    dig;
            logic [VALUE_BITS+4:0] wide;
            cons = 1'b0;
            done = 1'b0;
            if (c == CH_UNDER) begin
                cons = 1'b1;
                return;
            end
            if (c >= CH_0 && c <= CH_9) dv = c - CH_0;
            else if (c >= CH_LA && c <= CH_LF) dv = c - CH_LA + 10;
            else if (c >= CH_UA && c <= CH_UF) dv = c - CH_UA + 10;
            else dv = -1;
            if (dv < 0) begin
                phase = PH_IDLE;
                done  = 1'b1;
                return;
            end
            dig = RADIX_W'(dv);
            if (dig >= base) begin
                bad = 1'b1;
                dig = '0;
            end
            wide = acc * base + dig;
            if (|wide[VALUE_BITS+4:VALUE_BITS]) begin
                ovf = 1'b1;
                acc = '0;
                if (c >= CH_0 && c <= CH_9) begin
                    cons  = 1'b1;
                    phase = PH_SWALLOW;
                end else begin
                    phase = PH_IDLE;
                    done  = 1'b1;
                end
                return;
            end
            acc  = wide[VALUE_BITS-1:0];
            cons = 1'b1;
        endfunction

        function t_result predict_char(logic [7:0] c, logic s);
            t_result r;
            logic    cons;
            logic    done;
            cons = 1'b0;
            done = 1'b0;
            if (s) begin
                acc  = '0;
                base = RADIX_10;
                bad  = 1'b0;
                ovf  = 1'b0;
                if (c == CH_0) begin
                    phase = PH_ZERO;
                    cons  = 1'b1;
                end else begin
                    phase = PH_DIGITS;
                    add_digit(c, cons, done);
                end
            end else begin
                case (phase)
                    PH_ZERO: begin
                        phase = PH_DIGITS;
                        if (c == CH_LX || c == CH_UX) begin
                            base = RADIX_16;
                            cons = 1'b1;
                        end else if (c == CH_LB || c == CH_UB) begin
                            base = RADIX_2;
                            cons = 1'b1;
                        end else begin
                            base = RADIX_8;
                            add_digit(c, cons, done);
                        end
                    end
                    PH_DIGITS: add_digit(c, cons, done);
                    PH_SWALLOW: begin
                        if (c >= CH_0 && c <= CH_9) begin
                            cons = 1'b1;
                        end else begin
                            acc   = '0;
                            phase = PH_IDLE;
                            done  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            r.consumed = cons;
            r.done_res = done;
            if (done) begin
                r.value       = OUT_VALUE_W'(acc);
                r.radix       = base;
                r.digit_error = bad;
                r.overflow    = ovf;
            end else begin
                r.value       = '0;
                r.radix       = RADIX_10;
                r.digit_error = 1'b0;
                r.overflow    = 1'b0;
            end
            return r;
        endfunction

        function void note_char(logic [7:0] c, logic s);
            scan_results_due.push_back(predict_char(c, s));
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (scan_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: cons=%0b done=%0b value=%h",
                             $time, got.consumed, got.done_res, got.value);
                return;
            end
            want = scan_results_due.pop_front();
            if (got.consumed !== want.consumed || got.done_res !== want.done_res ||
                got.value !== want.value || got.radix !== want.radix ||
                got.digit_error !== want.digit_error || got.overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display({"%0t: mismatch, exp cons=%0b done=%0b value=%h radix=%0d ",
                              "derr=%0b ovf=%0b"},
                             $time, want.consumed, want.done_res, want.value, want.radix,
                             want.digit_error, want.overflow);
                    $display({"%0t:           got cons=%0b done=%0b value=%h radix=%0d ",
                              "derr=%0b ovf=%0b"},
                             $time, got.consumed, got.done_res, got.value, got.radix,
                             got.digit_error, got.overflow);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ils_in_if  in_if ();
    ils_out_if out_if ();

    integer_literal_scanner u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    literal_tracker tracker;

    int unsigned chars_sent;
    int unsigned noise_sent;
    int unsigned sink_hold_cycles;
    int unsigned calm_left [2];
    bit          calm_mode [2];
    bit          in_rush;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle draw per item; runs of zero-wait stretches alternate with random gaps.
    function automatic int unsigned draw_wait(int side);
        if (side == SIDE_IN && in_rush) return 0;
        if (calm_left[side] == 0) begin
            calm_mode[side] = ($urandom_range(0, 3) == 0);
            calm_left[side] = $urandom_range(10, 60);
        end
        calm_left[side]--;
        return calm_mode[side] ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [7:0] digit_char(int unsigned v);
        if (v < 10) return CH_0 + 8'(v);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    // A byte that is neither a digit, a hex letter nor an underscore.
    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
                   (c >= CH_UA && c <= CH_UF) || c == CH_UNDER);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic s);
        int unsigned gap;
        gap = draw_wait(SIDE_IN);
        @(negedge i_clk);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.ch        <= c;
        in_if.start_req <= s;
        do @(posedge i_clk); while (!in_if.ready);
        chars_sent++;
    endtask

    task automatic send_text(input string txt, input bit first_start);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], first_start && i == 0);
    endtask

    task automatic send_literal();
        int unsigned kind;
        int unsigned base;
        int unsigned maxlen;
        int unsigned len;
        int unsigned r;
        logic [7:0]  c;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            base   = 10;
            maxlen = 24;
            send_char(digit_char($urandom_range(1, 9)), 1'b1);
        end else if (kind <= 5) begin
            base   = 16;
            maxlen = 20;
            send_char(CH_0, 1'b1);
            send_char($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
        end else if (kind <= 7) begin
            base   = 2;
            maxlen = 70;
            send_char(CH_0, 1'b1);
            send_char($urandom_range(0, 1) ? CH_LB : CH_UB, 1'b0);
        end else if (kind == 8) begin
            base   = 8;
            maxlen = 25;
            send_char(CH_0, 1'b1);
        end else begin
            // start flag on an arbitrary byte
            base   = 10;
            maxlen = 24;
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end
        // long bodies land near the 64-bit limit so overflow shows up often
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(maxlen - 6, maxlen)
                                          : $urandom_range(0, 8);
        repeat (len) begin
            r = $urandom_range(0, 19);
            if (r == 0) c = CH_UNDER;
            else if (r == 1) c = digit_char($urandom_range(0, 15));
            else c = digit_char($urandom_range(0, base - 1));
            send_char(c, 1'b0);
        end
        r = $urandom_range(0, 9);
        if (r == 1) send_char(8'($urandom_range(0, 255)), 1'b0);
        else if (r != 0) send_char(pick_terminator(), 1'b0);
        // r == 0: no terminator, the next start flag cuts the literal short
    endtask

    always @(posedge i_clk) begin : monitor
        t_result seen;
        if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
            tracker.note_char(in_if.ch, in_if.start_req);
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen.consumed    = out_if.consumed;
            seen.done_res    = out_if.done_res;
            seen.value       = out_if.value;
            seen.radix       = out_if.radix;
            seen.digit_error = out_if.digit_error;
            seen.overflow    = out_if.overflow;
            tracker.check_result(seen);
        end
    end

    initial begin : result_sink
        int unsigned stall;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (sink_hold_cycles != 0) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (sink_hold_cycles) @(negedge i_clk);
                sink_hold_cycles = 0;
            end
            stall = draw_wait(SIDE_OUT);
            @(negedge i_clk);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    initial begin : stimulus
        bit pressed;
        in_if.valid     = 1'b0;
        in_if.ch        = '0;
        in_if.start_req = 1'b0;
        i_rst_n         = 1'b0;
        pressed         = 1'b0;
        tracker         = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_char("q", 1'b0);            // idle, no start: ignored
        send_text("0x1F ", 1'b1);
        send_text("0B12;", 1'b1);        // binary with a bad digit
        send_text("0_7g", 1'b1);         // lone zero, underscore, octal
        send_text("5", 1'b1);
        send_text("z", 1'b1);            // restart mid-literal on a non-digit
        send_text("_a", 1'b1);
        send_char(8'hFF, 1'b0);
        send_text("9", 1'b1);
        send_char(8'h00, 1'b0);

        chars_sent = 0;
        noise_sent = 0;
        while (chars_sent - noise_sent < RANDOM_ITEMS) begin
            if (!pressed && chars_sent >= 400) begin
                // sink stops while the source keeps pushing
                pressed          = 1'b1;
                sink_hold_cycles = 80;
                in_rush          = 1'b1;
                repeat (6) send_literal();
                in_rush = 1'b0;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_char(pick_terminator(), 1'b0);
                    noise_sent++;
                end
            end
            send_literal();
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (tracker.scan_results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.scan_results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- integer_literal_scanner.f -----
src/ils_pkg.sv
src/ils_if.sv
src/ils_step.sv
src/integer_literal_scanner.sv
bench/tb.sv
